// ===== design/rna_pkg.sv =====
// rna_pkg: shared types and constants of the rational number alu
// used by rna_ctrl, rna_dp and the top level rational_number_alu
package rna_pkg;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LT   = 3'd5,
    OP_GT   = 3'd6,
    OP_EQ   = 3'd7
  } op_e;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned ResNumWidth = 32;
  localparam int unsigned ResDenWidth = 31;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands, form products
    logic gcd_init;  // load gcd registers from products
    logic gcd_step;  // one binary gcd subtract-shift step
    logic div_init;  // start dividing num and den by gcd
    logic div_step;  // one restoring division bit
    logic finish;    // write output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;     // result needs no reduction
    logic gcd_done;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== design/rna_dp.sv =====
// rna_dp: datapath of the rational number alu
// cross products, binary gcd and two shared-step restoring dividers; uses rna_pkg
module rna_dp
  import rna_pkg::*;
#(
  parameter int unsigned OperandWidth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic [OpWidth-1:0]            op_i,
  input  logic signed [OperandWidth-1:0] a_num_i,
  input  logic signed [OperandWidth-1:0] a_den_i,
  input  logic signed [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-2:0]       b_den_i,
  output logic [ResNumWidth-1:0]        res_num_o,
  output logic [ResDenWidth-1:0]        res_den_o,
  output logic                          cmp_o,
  output logic                          err_o
);
  localparam int unsigned PW = 2 * OperandWidth + 2;   // signed product width
  localparam int unsigned MW = PW - 1;                 // magnitude width
  localparam int unsigned CW = $clog2(MW + 1);
  localparam int unsigned SW = $clog2(2 * MW + 2);

  logic signed [OperandWidth:0] an_s, ad_s, bn_s, bd_s;
  logic signed [PW-1:0] p1, p2, pn, pd;
  logic [MW-1:0] mn_d, md_d;
  logic          neg_d, early_d, err_d, cmp_d, nores_d;
  op_e op;

  logic [MW-1:0] mn_q, md_q, gx_q, gy_q, qn_q, qd_q, rn_q, rd_q;
  logic          neg_q, early_q, err_q, cmp_q, nores_q;
  logic [SW-1:0] tz_q;
  logic [CW-1:0] cnt_q;
  logic [ResNumWidth-1:0] res_num_q;
  logic [ResDenWidth-1:0] res_den_q;
  logic cmp_oq, err_oq;

  always_comb begin
    op   = op_e'(op_i);
    an_s = {a_num_i[OperandWidth-1], a_num_i};
    ad_s = {a_den_i[OperandWidth-1], a_den_i};
    bn_s = {b_num_i[OperandWidth-1], b_num_i};
    bd_s = {2'b00, b_den_i};
    if (a_den_i[OperandWidth-1]) begin
      an_s = -an_s;
      ad_s = -ad_s;
    end
    case (op)
      OP_NORM: begin
        p1 = PW'(an_s); p2 = '0; pn = PW'(an_s); pd = PW'(ad_s);
      end
      OP_MUL: begin
        p1 = '0; p2 = '0;
        pn = PW'(an_s) * PW'(bn_s); pd = PW'(ad_s) * PW'(bd_s);
      end
      OP_DIV: begin
        p1 = '0; p2 = '0;
        pn = PW'(an_s) * PW'(bd_s); pd = PW'(ad_s) * PW'(bn_s);
      end
      default: begin
        p1 = PW'(an_s) * PW'(bd_s); p2 = PW'(bn_s) * PW'(ad_s);
        pn = (op == OP_SUB) ? p1 - p2 : p1 + p2;
        pd = PW'(ad_s) * PW'(bd_s);
      end
    endcase
    if (pd[PW-1]) begin
      pn = -pn;
      pd = -pd;
    end
    neg_d = pn[PW-1];
    mn_d  = pn[PW-1] ? MW'(-pn) : MW'(pn);
    md_d  = MW'(pd);
    err_d = 1'b0;
    cmp_d = 1'b0;
    if (op == OP_EQ) begin
      cmp_d = (a_num_i == b_num_i) && (a_den_i == {1'b0, b_den_i});
    end else if (a_den_i == '0 || (op != OP_NORM && b_den_i == '0)
                 || (op == OP_DIV && b_num_i == '0)) begin
      err_d = 1'b1;
    end else if (op == OP_LT) begin
      cmp_d = p1 < p2;
    end else if (op == OP_GT) begin
      cmp_d = p1 > p2;
    end
    // errors and compares leave both fraction fields at zero
    nores_d = err_d || op == OP_EQ || op == OP_LT || op == OP_GT;
    early_d = nores_d || mn_d == '0;
  end

  // binary gcd: strip common twos, then subtract and shift odd parts
  logic [MW-1:0] gmin, gdif;
  always_comb begin
    gmin = (gx_q < gy_q) ? gx_q : gy_q;
    gdif = (gx_q < gy_q) ? gy_q - gx_q : gx_q - gy_q;
  end

  // restoring division, numerator and denominator side by side
  logic [MW-1:0] div_g;
  logic [MW:0]   tn, td;
  always_comb begin
    div_g = gx_q << tz_q;
    tn = {rn_q, qn_q[MW-1]};
    td = {rd_q, qd_q[MW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cmp_oq <= 1'b0;
      err_oq <= 1'b0;
    end else begin
      if (cmd_i.div_init) cnt_q <= CW'(MW);
      else if (cmd_i.div_step) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.finish) begin
        cmp_oq <= cmp_q;
        err_oq <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mn_q <= mn_d; md_q <= md_d; neg_q <= neg_d;
      early_q <= early_d; err_q <= err_d; cmp_q <= cmp_d; nores_q <= nores_d;
    end
    if (cmd_i.gcd_init) begin
      gx_q <= mn_q; gy_q <= md_q; tz_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; tz_q <= tz_q + 1'b1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else begin
        gx_q <= gmin; gy_q <= gdif;
      end
    end
    if (cmd_i.div_init) begin
      gx_q <= div_g; qn_q <= mn_q; qd_q <= md_q; rn_q <= '0; rd_q <= '0;
    end else if (cmd_i.div_step) begin
      if (tn >= {1'b0, gx_q}) begin
        rn_q <= MW'(tn - {1'b0, gx_q}); qn_q <= {qn_q[MW-2:0], 1'b1};
      end else begin
        rn_q <= MW'(tn); qn_q <= {qn_q[MW-2:0], 1'b0};
      end
      if (td >= {1'b0, gx_q}) begin
        rd_q <= MW'(td - {1'b0, gx_q}); qd_q <= {qd_q[MW-2:0], 1'b1};
      end else begin
        rd_q <= MW'(td); qd_q <= {qd_q[MW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      if (nores_q) begin
        res_num_q <= '0; res_den_q <= '0;
      end else if (mn_q == '0) begin
        res_num_q <= '0; res_den_q <= ResDenWidth'(1);
      end else begin
        res_num_q <= neg_q ? ResNumWidth'(-{1'b0, qn_q}) : ResNumWidth'({1'b0, qn_q});
        res_den_q <= ResDenWidth'(qd_q);
      end
    end
  end

  assign sts_o.early    = early_q;
  assign sts_o.gcd_done = (gy_q == '0) || (gx_q == '0);
  assign sts_o.div_done = (cnt_q == '0);
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign cmp_o     = cmp_oq;
  assign err_o     = err_oq;
endmodule

// ===== design/rna_ctrl.sv =====
// rna_ctrl: controller of the rational number alu
// sequences load, gcd, division and output; uses rna_pkg
module rna_ctrl
  import rna_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    out_fire_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    out_valid_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_GCD, S_DIVI, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) out_valid_q <= 1'b1;
      else if (out_fire_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_fire_i) state_q <= S_LOAD;
        S_LOAD: state_q <= sts_i.early ? S_OUT : S_GCD;
        S_GCD:  if (sts_i.gcd_done) state_q <= S_DIVI;
        S_DIVI: state_q <= S_DIV;
        S_DIV:  if (sts_i.div_done) state_q <= S_OUT;
        S_OUT:  if (!out_valid_q || out_fire_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_fire_i;
    cmd_o.gcd_init = (state_q == S_LOAD) && !sts_i.early;
    cmd_o.gcd_step = (state_q == S_GCD) && !sts_i.gcd_done;
    cmd_o.div_init = (state_q == S_DIVI);
    cmd_o.div_step = (state_q == S_DIV) && !sts_i.div_done;
    cmd_o.finish   = (state_q == S_OUT) && (!out_valid_q || out_fire_i);
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

// ===== design/rational_number_alu.sv =====
// rational_number_alu: top level of the fraction arithmetic unit
// Channels: s_axis carries one operation and two fractions per beat; m_axis
// returns one reduced fraction with compare and error flags per beat.
// s_axis_tdata fields from bit 0: operation, a_num, a_den, b_num, b_den.
// m_axis_tdata fields from bit 0: res_num, res_den, cmp_flag, error.
// One beat is processed at a time. Compare, equal, error and zero results
// skip reduction; all other results pass through the binary gcd loop and
// the one-bit-per-cycle shared divider.
// The next beat is accepted from the cycle after the result is registered,
// even while the result still waits.
// A stalled m_axis holds its beat; the controller waits before overwriting.
// Reset clears the controller and the output valid; no clearing pass.
module rational_number_alu
  import rna_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation, a_num, a_den, b_num, b_den from bit 0, zero padded
  input  logic [((OpWidth + 4*OPERAND_WIDTH - 1 + 7) / 8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_num, res_den, cmp_flag, error from bit 0
  output logic [71:0] m_axis_tdata
);
  localparam int unsigned W = OPERAND_WIDTH;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy, in_fire, out_fire, cmp, err;
  logic [ResNumWidth-1:0] rnum;
  logic [ResDenWidth-1:0] rden;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  rna_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_fire_i(out_fire),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .out_valid_o(m_axis_tvalid)
  );

  rna_dp #(.OperandWidth(W)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[OpWidth-1:0]),
    .a_num_i(s_axis_tdata[OpWidth+W-1:OpWidth]),
    .a_den_i(s_axis_tdata[OpWidth+2*W-1:OpWidth+W]),
    .b_num_i(s_axis_tdata[OpWidth+3*W-1:OpWidth+2*W]),
    .b_den_i(s_axis_tdata[OpWidth+4*W-2:OpWidth+3*W]),
    .res_num_o(rnum), .res_den_o(rden), .cmp_o(cmp), .err_o(err)
  );

  assign m_axis_tdata = {7'd0, err, cmp, rden, rnum};

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err |-> rnum == '0 && rden == '0) else $error("err result");
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat lost");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready) else $error("accepted while busy");
endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for rational_number_alu
// drives fraction operations on s_axis and checks m_axis beats against
// table expectations or a built-in fraction predictor; depends on rna_pkg and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rna_pkg::*;

  localparam int unsigned W = 16;
  localparam int unsigned IN_W = ((OpWidth + 4*W - 1 + 7) / 8)*8;
  localparam int NUM_RANDOM = 1900;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp;
    logic        err;
  } fraction_res_t;

  typedef struct {
    op_e         op;
    logic [15:0] an;
    logic [15:0] ad;
    logic [15:0] bn;
    logic [14:0] bd;
    bit          known;   // expectation typed into the table
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp;
    logic        err;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  fraction_res_t pending_q[$];
  int  errors = 0;
  bit  long_hold = 1'b0;
  longint cycles = 0;
  bit table_row_known = 1'b0;
  fraction_res_t table_res;

  rational_number_alu #(.OPERAND_WIDTH(W)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return (x == 0) ? 1 : x;
  endfunction

  function automatic void lowest_terms(inout longint n, inout longint d);
    longint unsigned g;
    longint unsigned mn;
    if (n == 0) begin
      d = 1;
      return;
    end
    mn = (n < 0) ? -n : n;
    g = gcd64(mn, d);
    n = (n < 0) ? -longint'(mn / g) : longint'(mn / g);
    d = d / g;
  endfunction

  function automatic fraction_res_t predict_fraction(op_e op, logic [15:0] an_v,
      logic [15:0] ad_v, logic [15:0] bn_v, logic [14:0] bd_v);
    fraction_res_t r;
    longint an, ad, bn, bd, rn, rd;
    an = longint'($signed(an_v));
    ad = longint'($signed(ad_v));
    bn = longint'($signed(bn_v));
    bd = longint'(bd_v);
    rn = 0;
    rd = 0;
    r.cmp = 1'b0;
    r.err = 1'b0;
    if (op == OP_EQ) begin
      r.cmp = (an == bn && ad == bd);
    end else if (ad == 0 || (op != OP_NORM && bd == 0)) begin
      r.err = 1'b1;
    end else begin
      if (ad < 0) begin
        an = -an;
        ad = -ad;
      end
      case (op)
        OP_NORM: begin rn = an; rd = ad; lowest_terms(rn, rd); end
        OP_ADD: begin rn = an*bd + bn*ad; rd = ad*bd; lowest_terms(rn, rd); end
        OP_SUB: begin rn = an*bd - bn*ad; rd = ad*bd; lowest_terms(rn, rd); end
        OP_MUL: begin rn = an*bn; rd = ad*bd; lowest_terms(rn, rd); end
        OP_DIV: begin
          if (bn == 0) begin
            r.err = 1'b1;
          end else begin
            rn = an*bd;
            rd = ad*bn;
            if (rd < 0) begin
              rn = -rn;
              rd = -rd;
            end
            lowest_terms(rn, rd);
          end
        end
        OP_LT: r.cmp = (an*bd < bn*ad);
        default: r.cmp = (an*bd > bn*ad);
      endcase
    end
    r.num = rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  // one beat on s_axis, held until accepted
  task automatic send_beat(op_e op, logic [15:0] an, logic [15:0] ad,
      logic [15:0] bn, logic [14:0] bd);
    s_axis_tdata <= IN_W'({bd, bn, ad, an, op});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // expectations are queued at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready && !table_row_known)
      pending_q.push_back(predict_fraction(op_e'(s_axis_tdata[2:0]),
        s_axis_tdata[18:3], s_axis_tdata[34:19], s_axis_tdata[50:35],
        s_axis_tdata[65:51]));
    else if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_q.push_back(table_res);
  end

  always @(posedge clk_i) begin
    fraction_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== e.num || m_axis_tdata[62:32] !== e.den ||
            m_axis_tdata[63] !== e.cmp || m_axis_tdata[64] !== e.err) begin
          $display("%0t: mismatch expected num=%0d den=%0d cmp=%b err=%b",
            $realtime, $signed(e.num), e.den, e.cmp, e.err);
          $display("%0t:          actual   num=%0d den=%0d cmp=%b err=%b",
            $realtime, $signed(m_axis_tdata[31:0]), m_axis_tdata[62:32],
            m_axis_tdata[63], m_axis_tdata[64]);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk_i);
        long_hold = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    @(posedge clk_i);
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL rational_number_alu");
    $finish;
  end

  function automatic vector_t row(op_e op, int an, int ad, int bn, int bd);
    vector_t v;
    v.op = op; v.an = 16'(an); v.ad = 16'(ad); v.bn = 16'(bn); v.bd = 15'(bd);
    v.known = 1'b0; v.num = '0; v.den = '0; v.cmp = 1'b0; v.err = 1'b0;
    return v;
  endfunction

  function automatic vector_t row_exp(op_e op, int an, int ad, int bn, int bd,
      int n, int d, bit c, bit e);
    vector_t v;
    v = row(op, an, ad, bn, bd);
    v.known = 1'b1; v.num = 32'(n); v.den = 31'(d); v.cmp = c; v.err = e;
    return v;
  endfunction

  initial begin
    vector_t directed[$];
    int i, burst, kind;
    op_e op;
    logic [15:0] an, ad, bn;
    logic [14:0] bd;

    directed.push_back(row_exp(OP_NORM, 6, -4, 0, 0, -3, 2, 0, 0));
    directed.push_back(row_exp(OP_NORM, 5, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(row_exp(OP_NORM, 0, -7, 0, 0, 0, 1, 0, 0));
    directed.push_back(row_exp(OP_ADD, 1, 2, 1, 0, 0, 0, 0, 1));
    directed.push_back(row_exp(OP_DIV, 1, 2, 0, 3, 0, 0, 0, 1));
    directed.push_back(row_exp(OP_ADD, 1, 2, -1, 2, 0, 1, 0, 0));
    directed.push_back(row_exp(OP_EQ, 3, -4, 3, 0, 0, 0, 0, 0));
    directed.push_back(row_exp(OP_EQ, -5, 7, -5, 7, 0, 0, 1, 0));
    directed.push_back(row_exp(OP_LT, 1, 0, 1, 1, 0, 0, 0, 1));
    directed.push_back(row(OP_NORM, -32768, -32768, 0, 0));
    directed.push_back(row(OP_ADD, 32767, 1, 32767, 1));
    directed.push_back(row(OP_SUB, -32768, 32767, 32767, 32767));
    directed.push_back(row(OP_MUL, -32768, -1, -32768, 32767));
    directed.push_back(row(OP_MUL, -32768, -32768, -32768, 1));
    directed.push_back(row(OP_DIV, 32767, -32768, -32768, 32767));
    directed.push_back(row(OP_DIV, -3, 4, -9, 2));
    directed.push_back(row(OP_LT, -1, 3, 1, 3));
    directed.push_back(row(OP_GT, 5, -3, -2, 1));
    directed.push_back(row(OP_GT, 32767, 32767, -32768, 32767));
    directed.push_back(row(OP_EQ, -32768, -32768, -32768, 32767));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      table_row_known <= directed[k].known;
      table_res <= '{directed[k].num, directed[k].den, directed[k].cmp,
                     directed[k].err};
      send_beat(directed[k].op, directed[k].an, directed[k].ad, directed[k].bn,
        directed[k].bd);
    end
    table_row_known <= 1'b0;
    idle_sender();

    i = 0;
    while (i < NUM_RANDOM) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && i < NUM_RANDOM) begin
        if (i == 300) long_hold = 1'b1;
        if (i == 1000) begin
          // sender waits for every result to drain
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_q.size() != 0) @(posedge clk_i);
        end
        op = op_e'($urandom_range(0, 7));
        kind = $urandom_range(0, 9);
        an = 16'($urandom);
        bn = 16'($urandom);
        ad = 16'($urandom);
        bd = 15'($urandom);
        if (kind < 4) begin
          // small operands, frequent common factors
          an = $signed(16'($urandom_range(0, 48))) - 16'sd24;
          bn = $signed(16'($urandom_range(0, 48))) - 16'sd24;
          ad = $signed(16'($urandom_range(0, 48))) - 16'sd24;
          bd = 15'($urandom_range(0, 24));
        end else if (kind == 4) begin
          ad = (ad[0]) ? 16'h8000 : 16'h7fff;
        end else if (kind == 5 && op == OP_EQ) begin
          bn = an;
          bd = ad[14:0];
        end
        if (kind < 9 && ad == 0) ad = 1;
        if (kind < 9 && bd == 0) bd = 1;
        send_beat(op, an, ad, bn, bd);
        i++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS rational_number_alu");
    end else begin
      $display("FAIL rational_number_alu");
    end
    $finish;
  end

endmodule
